>>> rtl/assert_macros.svh
// Assertion macros shared by the solver RTL.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted
`define QRS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked property, checked during reset as well
`define QRS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> rtl/qrs_pkg.sv
// Shared widths, status codes and sideband types for the quadratic root solver.
// No dependencies.
`default_nettype none

package qrs_pkg;

    localparam int COEF_W      = 16;
    localparam int FRAC_BITS   = 16;
    localparam int STATUS_W    = 2;
    localparam int DISC_W      = 2 * COEF_W + 2;
    localparam int ROOT_W      = 43;
    // root of disc * 2^(2*FRAC_BITS): one bit per cell
    localparam int SQ_ROOT_W   = DISC_W / 2 + FRAC_BITS;
    localparam int SQ_CELLS    = SQ_ROOT_W;
    localparam int SQ_REM_W    = SQ_ROOT_W + 2;
    // numerator -b*2^F +/- s, signed
    localparam int NUM_W       = SQ_ROOT_W + 2;
    localparam int MAG_W       = NUM_W - 1;
    localparam int DEN_W       = COEF_W + 1;
    localparam int DIV_CELLS   = MAG_W;
    localparam int IN_FIELDS_W = 3 * COEF_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = STATUS_W + DISC_W + 2 * ROOT_W;
    localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [STATUS_W-1:0] {
        ST_NOT_QUAD  = 2'd0,
        ST_NO_REAL   = 2'd1,
        ST_ONE_ROOT  = 2'd2,
        ST_TWO_ROOTS = 2'd3
    } t_status;

    // travels beside the square root cells
    typedef struct packed {
        t_status                  status;
        logic [DISC_W-1:0]        disc;
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
    } t_sq_side;

    // travels beside the divider cells
    typedef struct packed {
        t_status           status;
        logic [DISC_W-1:0] disc;
        logic              neg_m;
        logic              neg_p;
    } t_div_side;

endpackage

`default_nettype wire

>>> rtl/qrs_front.sv
// Front end: coefficient products, exact discriminant and classification.
// Depends on qrs_pkg.
`default_nettype none

module qrs_front import qrs_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_valid,
    input  wire logic signed [COEF_W-1:0] i_a,
    input  wire logic signed [COEF_W-1:0] i_b,
    input  wire logic signed [COEF_W-1:0] i_c,
    output logic                          o_valid,
    output logic [DISC_W-1:0]             o_rad,
    output t_sq_side                      o_side
);

    logic                       r_v1;
    logic signed [COEF_W-1:0]   r_a1;
    logic signed [COEF_W-1:0]   r_b1;
    logic signed [2*COEF_W-1:0] r_bb;
    logic signed [2*COEF_W-1:0] r_ac;

    logic signed [DISC_W-1:0]   n_disc;
    t_status                    n_status;

    // stage 1: products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
        if (i_en) begin
            r_a1 <= i_a;
            r_b1 <= i_b;
            r_bb <= i_b * i_b;
            r_ac <= i_a * i_c;
        end
    end

    // discriminant and class
    always_comb begin
        n_disc = DISC_W'(r_bb) - (DISC_W'(r_ac) <<< 2);
        if (r_a1 == '0) begin
            n_status = ST_NOT_QUAD;
        end else if (n_disc[DISC_W-1]) begin
            n_status = ST_NO_REAL;
        end else if (n_disc == '0) begin
            n_status = ST_ONE_ROOT;
        end else begin
            n_status = ST_TWO_ROOTS;
        end
    end

    // stage 2: feed the square root chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v1;
        end
        if (i_en) begin
            o_rad         <= n_disc;
            o_side.status <= n_status;
            o_side.disc   <= (n_status == ST_NOT_QUAD) ? '0 : n_disc;
            o_side.a      <= r_a1;
            o_side.b      <= r_b1;
        end
    end

endmodule

`default_nettype wire

>>> rtl/qrs_sq_cell.sv
// One square root cell: takes the next radicand bit pair, settles one root bit.
// Depends on qrs_pkg.
`default_nettype none

module qrs_sq_cell import qrs_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire logic [DISC_W-1:0]    i_rad,
    input  wire logic [SQ_REM_W-1:0]  i_rem,
    input  wire logic [SQ_ROOT_W-1:0] i_root,
    input  wire t_sq_side             i_side,
    output logic                      o_valid,
    output logic [DISC_W-1:0]         o_rad,
    output logic [SQ_REM_W-1:0]       o_rem,
    output logic [SQ_ROOT_W-1:0]      o_root,
    output t_sq_side                  o_side
);

    logic [SQ_REM_W-1:0] w_rem2;
    logic [SQ_REM_W-1:0] w_trial;
    logic                w_ge;

    // trial subtract of 4*root+1
    always_comb begin
        w_rem2  = {i_rem[SQ_REM_W-3:0], i_rad[DISC_W-1 -: 2]};
        w_trial = {i_root, 2'b01};
        w_ge    = (w_rem2 >= w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_rad  <= {i_rad[DISC_W-3:0], 2'b00};
            o_rem  <= w_ge ? (w_rem2 - w_trial) : w_rem2;
            o_root <= {i_root[SQ_ROOT_W-2:0], w_ge};
            o_side <= i_side;
        end
    end

endmodule

`default_nettype wire

>>> rtl/qrs_div_cell.sv
// One divider cell: one restoring quotient bit for both root numerators.
// Depends on qrs_pkg.
`default_nettype none

module qrs_div_cell import qrs_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire logic [1:0][MAG_W-1:0]      i_nq,
    input  wire logic [1:0][DEN_W-1:0]      i_rem,
    input  wire logic [DEN_W-1:0]           i_den,
    input  wire t_div_side                  i_side,
    output logic                            o_valid,
    output logic [1:0][MAG_W-1:0]           o_nq,
    output logic [1:0][DEN_W-1:0]           o_rem,
    output logic [DEN_W-1:0]                o_den,
    output t_div_side                       o_side
);

    logic [1:0][DEN_W:0]   w_rem2;
    logic [1:0]            w_ge;
    logic [1:0][DEN_W-1:0] n_rem;
    logic [1:0][MAG_W-1:0] n_nq;

    // per lane: shift in numerator bit, compare, subtract
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_rem2[l] = {i_rem[l], i_nq[l][MAG_W-1]};
            w_ge[l]   = (w_rem2[l] >= {1'b0, i_den});
            n_rem[l]  = w_ge[l] ? DEN_W'(w_rem2[l] - {1'b0, i_den})
                                : DEN_W'(w_rem2[l]);
            n_nq[l]   = {i_nq[l][MAG_W-2:0], w_ge[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_nq   <= n_nq;
            o_rem  <= n_rem;
            o_den  <= i_den;
            o_side <= i_side;
        end
    end

endmodule

`default_nettype wire

>>> rtl/quadratic_root_solver_core.sv
// Registers from input transaction to result: 2 front, 33 root, 1 setup, 34 divide,
// 1 output register. Throughput: one transaction per cycle while the pipeline is not halted.
// The pipeline halts as a whole only while the output register holds an untaken
// result and the last cell is occupied; an empty last cell lets it advance.
// Reset: i_rst_n synchronous, active low, clears every valid flag.
// Depends on qrs_pkg, qrs_front, qrs_sq_cell, qrs_div_cell, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module quadratic_root_solver_core import qrs_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    // [15:0] coef_a, [31:16] coef_b, [47:32] coef_c
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    // [1:0] status, [35:2] discriminant, [78:36] root_minus, [121:79] root_plus
    output logic [OUT_TDATA_W-1:0]      o_m_tdata
);

    logic w_en;

    // square root chain wiring
    logic [SQ_CELLS:0]    w_sq_v;
    logic [DISC_W-1:0]    w_sq_rad  [SQ_CELLS+1];
    logic [SQ_REM_W-1:0]  w_sq_rem  [SQ_CELLS+1];
    logic [SQ_ROOT_W-1:0] w_sq_root [SQ_CELLS+1];
    t_sq_side             w_sq_side [SQ_CELLS+1];

    // divider chain wiring
    logic [DIV_CELLS:0]    w_dv_v;
    logic [1:0][MAG_W-1:0] w_dv_nq   [DIV_CELLS+1];
    logic [1:0][DEN_W-1:0] w_dv_rem  [DIV_CELLS+1];
    logic [DEN_W-1:0]      w_dv_den  [DIV_CELLS+1];
    t_div_side             w_dv_side [DIV_CELLS+1];

    logic signed [NUM_W-1:0] w_nb;
    logic signed [NUM_W-1:0] w_num_m;
    logic signed [NUM_W-1:0] w_num_p;
    logic [COEF_W-1:0]       w_a_mag;
    t_sq_side                w_last_sq;

    logic                    r_mid_v;
    logic [1:0][MAG_W-1:0]   r_mid_nq;
    logic [DEN_W-1:0]        r_mid_den;
    t_div_side               r_mid_side;

    logic [ROOT_W-1:0]       w_rm;
    logic [ROOT_W-1:0]       w_rp;
    t_div_side               w_last_dv;

    // advance unless a held result blocks an occupied last cell
    assign w_en       = !w_dv_v[DIV_CELLS] || !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    qrs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_a     (i_s_tdata[COEF_W-1:0]),
        .i_b     (i_s_tdata[2*COEF_W-1:COEF_W]),
        .i_c     (i_s_tdata[3*COEF_W-1:2*COEF_W]),
        .o_valid (w_sq_v[0]),
        .o_rad   (w_sq_rad[0]),
        .o_side  (w_sq_side[0])
    );

    assign w_sq_rem[0]  = '0;
    assign w_sq_root[0] = '0;

    for (genvar g = 0; g < SQ_CELLS; g++) begin : g_sq
        qrs_sq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sq_v[g]),
            .i_rad   (w_sq_rad[g]),
            .i_rem   (w_sq_rem[g]),
            .i_root  (w_sq_root[g]),
            .i_side  (w_sq_side[g]),
            .o_valid (w_sq_v[g+1]),
            .o_rad   (w_sq_rad[g+1]),
            .o_rem   (w_sq_rem[g+1]),
            .o_root  (w_sq_root[g+1]),
            .o_side  (w_sq_side[g+1])
        );
    end

    // numerators, magnitudes and quotient signs
    always_comb begin
        w_last_sq = w_sq_side[SQ_CELLS];
        w_nb      = (-NUM_W'(w_last_sq.b)) <<< FRAC_BITS;
        w_num_m   = w_nb - signed'(NUM_W'(w_sq_root[SQ_CELLS]));
        w_num_p   = w_nb + signed'(NUM_W'(w_sq_root[SQ_CELLS]));
        w_a_mag   = w_last_sq.a[COEF_W-1] ? COEF_W'(-w_last_sq.a) : COEF_W'(w_last_sq.a);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_v <= 1'b0;
        end else if (w_en) begin
            r_mid_v <= w_sq_v[SQ_CELLS];
        end
        if (w_en) begin
            r_mid_nq[0]       <= w_num_m[NUM_W-1] ? MAG_W'(-w_num_m) : MAG_W'(w_num_m);
            r_mid_nq[1]       <= w_num_p[NUM_W-1] ? MAG_W'(-w_num_p) : MAG_W'(w_num_p);
            r_mid_den         <= {w_a_mag, 1'b0};
            r_mid_side.status <= w_last_sq.status;
            r_mid_side.disc   <= w_last_sq.disc;
            r_mid_side.neg_m  <= w_num_m[NUM_W-1] ^ w_last_sq.a[COEF_W-1];
            r_mid_side.neg_p  <= w_num_p[NUM_W-1] ^ w_last_sq.a[COEF_W-1];
        end
    end

    assign w_dv_v[0]    = r_mid_v;
    assign w_dv_nq[0]   = r_mid_nq;
    assign w_dv_rem[0]  = '0;
    assign w_dv_den[0]  = r_mid_den;
    assign w_dv_side[0] = r_mid_side;

    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
        qrs_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_dv_v[g]),
            .i_nq    (w_dv_nq[g]),
            .i_rem   (w_dv_rem[g]),
            .i_den   (w_dv_den[g]),
            .i_side  (w_dv_side[g]),
            .o_valid (w_dv_v[g+1]),
            .o_nq    (w_dv_nq[g+1]),
            .o_rem   (w_dv_rem[g+1]),
            .o_den   (w_dv_den[g+1]),
            .o_side  (w_dv_side[g+1])
        );
    end

    // signed roots, zeroed where the class has none
    always_comb begin
        w_last_dv = w_dv_side[DIV_CELLS];
        w_rm = w_last_dv.neg_m ? -ROOT_W'(w_dv_nq[DIV_CELLS][0])
                               :  ROOT_W'(w_dv_nq[DIV_CELLS][0]);
        w_rp = w_last_dv.neg_p ? -ROOT_W'(w_dv_nq[DIV_CELLS][1])
                               :  ROOT_W'(w_dv_nq[DIV_CELLS][1]);
        if (w_last_dv.status == ST_NOT_QUAD || w_last_dv.status == ST_NO_REAL) begin
            w_rm = '0;
            w_rp = '0;
        end else if (w_last_dv.status == ST_ONE_ROOT) begin
            w_rp = '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_tvalid <= 1'b0;
        end else if (!o_m_tvalid || i_m_tready) begin
            o_m_tvalid <= w_dv_v[DIV_CELLS];
        end
        if (!o_m_tvalid || i_m_tready) begin
            o_m_tdata <= OUT_TDATA_W'({w_rp, w_rm, w_last_dv.disc, w_last_dv.status});
        end
    end

    `QRS_ASSERT(a_notquad_zero,
        (o_m_tvalid && o_m_tdata[STATUS_W-1:0] == ST_NOT_QUAD) |->
            (o_m_tdata[OUT_TDATA_W-1:STATUS_W] == '0),
        "not-quadratic result carries nonzero fields")
    `QRS_ASSERT(a_noreal_roots_zero,
        (o_m_tvalid && o_m_tdata[STATUS_W-1:0] == ST_NO_REAL) |->
            (o_m_tdata[OUT_FIELDS_W-1:STATUS_W+DISC_W] == '0 &&
             o_m_tdata[STATUS_W+DISC_W-1]),
        "no-real-roots result has roots or a nonnegative discriminant")
    `QRS_ASSERT(a_one_root_disc,
        (o_m_tvalid && o_m_tdata[STATUS_W-1:0] == ST_ONE_ROOT) |->
            (o_m_tdata[STATUS_W+DISC_W-1:STATUS_W] == '0 &&
             o_m_tdata[OUT_FIELDS_W-1:STATUS_W+DISC_W+ROOT_W] == '0),
        "single-root result inconsistent")
    `QRS_ASSERT(a_stall_only_when_full,
        !o_s_tready |-> (o_m_tvalid && !i_m_tready && w_dv_v[DIV_CELLS]),
        "input stalled without a blocked result")

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking bench for quadratic_root_solver_core: predicts status, discriminant and roots.
// Depends on qrs_pkg and the solver RTL only.
`default_nettype none

module testbench import qrs_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_status              status;
        logic [DISC_W-1:0]    disc;
        logic [ROOT_W-1:0]    r_minus;
        logic [ROOT_W-1:0]    r_plus;
    } t_solution;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    // [15:0] coef_a, [31:16] coef_b, [47:32] coef_c
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // [1:0] status, [35:2] discriminant, [78:36] root_minus, [121:79] root_plus
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    t_solution solutions_due[$];
    int        n_errors = 0;
    int        n_sent = 0;
    int        n_checked = 0;
    int        n_status[4] = '{default: 0};
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    bit        hold_sink = 1'b0;
    int        idle_cycles = 0;

    localparam int WATCHDOG_LIMIT = 20000;

    quadratic_root_solver_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    // floor(sqrt(d) * 2^FRAC_BITS), bitwise restoring method
    function automatic logic [63:0] fixed_sqrt(input logic [63:0] d);
        logic [63:0] rem, root, trial, pair;
        rem = '0;
        root = '0;
        for (int i = 31 + FRAC_BITS; i >= 0; i--) begin
            pair = (i >= FRAC_BITS) ? ((d >> (2 * (i - FRAC_BITS))) & 64'd3) : 64'd0;
            rem = (rem << 2) | pair;
            root = root << 1;
            trial = (root << 1) | 64'd1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = root | 64'd1;
            end
        end
        return root;
    endfunction

    function automatic t_solution solve_quadratic(input logic signed [COEF_W-1:0] a,
                                                  input logic signed [COEF_W-1:0] b,
                                                  input logic signed [COEF_W-1:0] c);
        t_solution sol;
        longint d, den, nb, s;
        sol = '0;
        sol.status = ST_NOT_QUAD;
        if (a != 0) begin
            d = longint'(b) * longint'(b) - 64'sd4 * longint'(a) * longint'(c);
            sol.disc = d[DISC_W-1:0];
            if (d < 0) begin
                sol.status = ST_NO_REAL;
            end else begin
                den = 2 * longint'(a);
                nb = -longint'(b) * (64'sd1 <<< FRAC_BITS);
                s = longint'(fixed_sqrt(d));
                sol.r_minus = ROOT_W'((nb - s) / den);
                if (d == 0) begin
                    sol.status = ST_ONE_ROOT;
                end else begin
                    sol.status = ST_TWO_ROOTS;
                    sol.r_plus = ROOT_W'((nb + s) / den);
                end
            end
        end
        return sol;
    endfunction

    // one input transaction, with optional idle gaps ahead of it
    task automatic send_coefs(input logic [15:0] a, input logic [15:0] b, input logic [15:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {a, b, c} == 0 ? '0 : IN_TDATA_W'({c, b, a});
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        solutions_due.push_back(solve_quadratic(a, b, c));
        n_sent++;
    endtask

    // source goes quiet until every expected result is back
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (solutions_due.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // receiver stalls
    always @(posedge i_clk) begin
        i_m_tready <= !hold_sink && ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        t_solution got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_solution'({o_m_tdata[1:0], o_m_tdata[35:2], o_m_tdata[78:36],
                               o_m_tdata[121:79]});
            if (solutions_due.size() == 0) begin
                $display("%0t ERROR: unexpected result %h", $time, got);
                n_errors++;
            end else begin
                want = solutions_due.pop_front();
                n_checked++;
                n_status[want.status]++;
                if (got.status !== want.status) begin
                    $display("%0t ERROR status exp %0d got %0d", $time, want.status, got.status);
                    n_errors++;
                end
                if (got.disc !== want.disc) begin
                    $display("%0t ERROR disc exp %h got %h", $time, want.disc, got.disc);
                    n_errors++;
                end
                if (got.r_minus !== want.r_minus) begin
                    $display("%0t ERROR root_minus exp %h got %h", $time, want.r_minus,
                             got.r_minus);
                    n_errors++;
                end
                if (got.r_plus !== want.r_plus) begin
                    $display("%0t ERROR root_plus exp %h got %h", $time, want.r_plus,
                             got.r_plus);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d results pending", solutions_due.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic test_directed();
        logic [15:0] ext[5];
        ext = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff};
        send_coefs(16'd0, 16'd5, 16'd3);            // not quadratic
        send_coefs(16'd1, 16'd0, 16'd1);            // no real roots
        send_coefs(16'd1, 16'd2, 16'd1);            // single root
        send_coefs(16'd1, 16'hfffd, 16'd2);         // two roots 1 and 2
        send_coefs(16'd2, 16'd0, 16'hfffd);         // irrational roots
        send_coefs(16'h8000, 16'h8000, 16'h7fff);   // largest discriminant
        send_coefs(16'h8000, 16'h0000, 16'h8000);   // most negative discriminant
        for (int i = 0; i < 5; i++) begin
            send_coefs(ext[i], ext[(i + 1) % 5], ext[(i + 3) % 5]);
            send_coefs(ext[i], ext[i], ext[(i + 2) % 5]);
        end
        send_coefs(16'hffff, 16'h7fff, 16'h8000);
        send_coefs(16'h7fff, 16'h0001, 16'h0000);
        drain_results();
    endtask

    task automatic send_random();
        logic [15:0] a, b, c;
        int kind;
        kind = $urandom_range(9);
        a = 16'($urandom);
        b = 16'($urandom);
        c = 16'($urandom);
        case (kind)
            0: a = 16'd0;
            1: begin                                 // perfect square: a(x-r)^2
                a = 16'($urandom_range(1, 60) * ($urandom_range(1) ? 1 : -1));
                b = 16'($signed(a) * 2 * $signed(16'($urandom_range(0, 40)) - 16'sd20));
                c = 16'(($signed(b) * $signed(b)) / (4 * $signed(a)));
            end
            2: begin                                 // small values
                a = 16'($urandom_range(0, 14) - 7);
                b = 16'($urandom_range(0, 14) - 7);
                c = 16'($urandom_range(0, 14) - 7);
            end
            default: ;
        endcase
        send_coefs(a, b, c);
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_random();
        drain_results();
    endtask

    // sink holds off while the source keeps offering, then source waits for the drain
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_sink = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_sink = 1'b0;
            end
            repeat (150) send_random();
        join
        drain_results();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_phase(0, 0, 250);
        test_random_phase(58, 0, 250);
        test_random_phase(0, 58, 250);
        test_random_phase(33, 33, 250);
        test_backpressure();
        $display("Checked %0d of %0d coefficient sets: %0d linear, %0d complex,",
                 n_checked, n_sent, n_status[0], n_status[1]);
        $display("%0d single, %0d pairs; phases covered free flow, source gaps, sink stalls,",
                 n_status[2], n_status[3]);
        $display("both, and a long sink hold-off");
        if (n_errors == 0 && solutions_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

`default_nettype wire
